/* hdl/sbfg_pkg.sv */
// ----------------------------------------------------------------------------
// Servo bus frame generator package
// Shared types, codes and the CRC-16 byte update for the frame generator.
// ----------------------------------------------------------------------------
package sbfg_pkg;

   localparam int POS_W_MAX = 16;

   localparam logic [1:0] MODE_SET_RAW   = 2'd0;
   localparam logic [1:0] MODE_SET_ANGLE = 2'd1;
   localparam logic [1:0] MODE_SYNC      = 2'd2;
   localparam logic [1:0] MODE_READ      = 2'd3;

   localparam logic [1:0] CSR_ID_OFFSET       = 2'd0;
   localparam logic [1:0] CSR_GOAL_ADDRESS    = 2'd1;
   localparam logic [1:0] CSR_PRESENT_ADDRESS = 2'd2;

   localparam logic [7:0]  ID_OFFSET_RESET       = 8'd11;
   localparam logic [15:0] GOAL_ADDRESS_RESET    = 16'h0074;
   localparam logic [15:0] PRESENT_ADDRESS_RESET = 16'd132;

   localparam logic [7:0]  HDR_MARK         = 8'hFF;
   localparam logic [7:0]  HDR_FLAG         = 8'hFD;
   localparam logic [7:0]  HDR_RESERVED     = 8'h00;
   localparam logic [7:0]  BROADCAST_ID     = 8'hFE;
   localparam logic [7:0]  INSTR_SYNC_WRITE = 8'h83;
   localparam logic [7:0]  INSTR_READ       = 8'h02;
   localparam logic [7:0]  DATA_SIZE        = 8'h04;
   localparam logic [7:0]  READ_LENGTH      = 8'd7;
   localparam logic [15:0] CRC_POLY         = 16'h8005;

   localparam logic [3:0] HEAD_LAST  = 4'd11;
   localparam logic [2:0] SLOT_LAST  = 3'd4;

   typedef enum logic [1:0] {
      CMD_SET,
      CMD_SYNC,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [2:0]           index;
      logic [POS_W_MAX-1:0] position;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  id_offset;
      logic [15:0] goal_address;
      logic [15:0] present_address;
   } cfg_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/sbfg_req_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command to the frame generator.
// ----------------------------------------------------------------------------
interface sbfg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [2:0]         servo_index;
   logic signed [16:0] target_value;

   modport source (output valid, output mode, output servo_index, output target_value,
                   input ready);
   modport sink (input valid, input mode, input servo_index, input target_value,
                 output ready);
endinterface

/* hdl/sbfg_rsp_if.sv */
// ----------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel that carries one frame byte and its end marker.
// ----------------------------------------------------------------------------
interface sbfg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;

   modport source (output valid, output tx_byte, output last_byte, input ready);
   modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

/* hdl/sbfg_front.sv */
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, clamps positions, queues all but bad-index set commands.
// ----------------------------------------------------------------------------
module sbfg_front #(
   parameter int SERVO_COUNT   = 5,
   parameter int POSITION_BITS = 12
) (
   sbfg_req_if.sink         req_ch,
   input  logic             q_full,
   output logic             q_push,
   output sbfg_pkg::cmd_type q_cmd
);
   import sbfg_pkg::*;

   localparam logic [16:0] POS_MAX = 17'((1 << POSITION_BITS) - 1);
   localparam logic signed [17:0] HALF    = 18'(1 << (POSITION_BITS - 1));
   localparam logic signed [17:0] LIM     = HALF - 18'sd1;
   localparam logic signed [17:0] NEG_LIM = -LIM;

   logic [16:0]              raw;
   logic signed [17:0]       angle;
   logic signed [17:0]       clamped;
   logic signed [17:0]       offset;
   logic [POSITION_BITS-1:0] pos;
   logic                     keep;
   logic                     in_range;

   assign raw      = unsigned'(req_ch.target_value);
   assign angle    = {req_ch.target_value[16], req_ch.target_value};
   assign in_range = int'(req_ch.servo_index) < SERVO_COUNT;

   always_comb begin
      if (angle >= HALF) begin
         clamped = LIM;
      end else if (angle <= -HALF) begin
         clamped = NEG_LIM;
      end else begin
         clamped = angle;
      end
      offset = clamped + LIM;
   end

   always_comb begin
      q_cmd.index    = req_ch.servo_index;
      q_cmd.kind     = CMD_SET;
      pos            = '0;
      keep           = 1'b0;
      unique case (req_ch.mode)
         MODE_SET_RAW: begin
            pos  = (raw > POS_MAX) ? POS_MAX[POSITION_BITS-1:0] : raw[POSITION_BITS-1:0];
            keep = in_range;
         end
         MODE_SET_ANGLE: begin
            pos  = offset[POSITION_BITS-1:0];
            keep = in_range;
         end
         MODE_SYNC: begin
            q_cmd.kind = CMD_SYNC;
            keep       = 1'b1;
         end
         MODE_READ: begin
            q_cmd.kind = CMD_READ;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      q_cmd.position = POS_W_MAX'(pos);
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full && keep;

endmodule

/* hdl/sbfg_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the front end from the frame sequencer.
// ----------------------------------------------------------------------------
module sbfg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbfg_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              pop_valid,
   output sbfg_pkg::cmd_type pop_cmd
);
   import sbfg_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue holds more than two commands");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");

endmodule

/* hdl/sbfg_back.sv */
// ----------------------------------------------------------------------------
// Frame sequencer
// Holds the goal table and emits sync-write and read-request frames bytewise.
// ----------------------------------------------------------------------------
module sbfg_back #(
   parameter int SERVO_COUNT   = 5,
   parameter int POSITION_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  sbfg_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  sbfg_pkg::cmd_type q_cmd,
   output logic              q_pop,
   sbfg_rsp_if.source        rsp_ch
);
   import sbfg_pkg::*;

   localparam int SW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [SW-1:0] SERVO_LAST = SW'(SERVO_COUNT - 1);
   localparam logic [7:0]    SYNC_LENGTH = 8'(7 + 5 * SERVO_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_SERVO,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   state_type                state_ff, state_in;
   logic                     read_kind_ff, read_kind_in;
   logic [2:0]               req_idx_ff, req_idx_in;
   logic [3:0]               head_ff, head_in;
   logic [SW-1:0]            servo_ff, servo_in;
   logic [2:0]               slot_ff, slot_in;
   logic [15:0]              crc_ff, crc_in;
   logic [POSITION_BITS-1:0] goal_ff [SERVO_COUNT];
   logic [POSITION_BITS-1:0] goal_in [SERVO_COUNT];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               tx_ff, tx_in;
   logic                     last_ff, last_in;

   logic                     out_free;
   logic                     load_out;
   logic [7:0]               head_byte;
   logic [7:0]               servo_byte;
   logic [POS_W_MAX-1:0]     cur_pos;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign cur_pos  = POS_W_MAX'(goal_ff[servo_ff]);

   always_comb begin
      case (head_ff)
         4'd0, 4'd1: head_byte = HDR_MARK;
         4'd2:       head_byte = HDR_FLAG;
         4'd3:       head_byte = HDR_RESERVED;
         4'd4:       head_byte = read_kind_ff ? cfg.id_offset + 8'(req_idx_ff) : BROADCAST_ID;
         4'd5:       head_byte = read_kind_ff ? READ_LENGTH : SYNC_LENGTH;
         4'd6:       head_byte = 8'h00;
         4'd7:       head_byte = read_kind_ff ? INSTR_READ : INSTR_SYNC_WRITE;
         4'd8:       head_byte = read_kind_ff ? cfg.present_address[7:0]
                                              : cfg.goal_address[7:0];
         4'd9:       head_byte = read_kind_ff ? cfg.present_address[15:8]
                                              : cfg.goal_address[15:8];
         4'd10:      head_byte = DATA_SIZE;
         default:    head_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (slot_ff)
         3'd0:    servo_byte = cfg.id_offset + 8'(servo_ff);
         3'd1:    servo_byte = cur_pos[7:0];
         3'd2:    servo_byte = cur_pos[15:8];
         default: servo_byte = 8'h00;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      read_kind_in = read_kind_ff;
      req_idx_in   = req_idx_ff;
      head_in      = head_ff;
      servo_in     = servo_ff;
      slot_in      = slot_ff;
      crc_in       = crc_ff;
      goal_in      = goal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      tx_in        = tx_ff;
      last_in      = last_ff;
      load_out     = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_cmd.kind == CMD_SET) begin
                  for (int k = 0; k < SERVO_COUNT; k++) begin
                     if (int'(q_cmd.index) == k) begin
                        goal_in[k] = q_cmd.position[POSITION_BITS-1:0];
                     end
                  end
               end else begin
                  read_kind_in = q_cmd.kind == CMD_READ;
                  req_idx_in   = q_cmd.index;
                  crc_in       = '0;
                  head_in      = '0;
                  state_in     = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               load_out = 1'b1;
               tx_in    = head_byte;
               last_in  = 1'b0;
               crc_in   = crc16_byte(crc_ff, head_byte);
               if (head_ff == HEAD_LAST) begin
                  servo_in = '0;
                  slot_in  = '0;
                  state_in = read_kind_ff ? ST_CRC_LO : ST_SERVO;
               end else begin
                  head_in = head_ff + 4'd1;
               end
            end
         end
         ST_SERVO: begin
            if (out_free) begin
               load_out = 1'b1;
               tx_in    = servo_byte;
               last_in  = 1'b0;
               crc_in   = crc16_byte(crc_ff, servo_byte);
               if (slot_ff == SLOT_LAST) begin
                  slot_in = '0;
                  if (servo_ff == SERVO_LAST) begin
                     state_in = ST_CRC_LO;
                  end else begin
                     servo_in = servo_ff + SW'(1);
                  end
               end else begin
                  slot_in = slot_ff + 3'd1;
               end
            end
         end
         ST_CRC_LO: begin
            if (out_free) begin
               load_out = 1'b1;
               tx_in    = crc_ff[7:0];
               last_in  = 1'b0;
               state_in = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (out_free) begin
               load_out = 1'b1;
               tx_in    = crc_ff[15:8];
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_kind_ff <= 1'b0;
         req_idx_ff   <= '0;
         head_ff      <= '0;
         servo_ff     <= '0;
         slot_ff      <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SERVO_COUNT; k++) begin
            goal_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         read_kind_ff <= read_kind_in;
         req_idx_ff   <= req_idx_in;
         head_ff      <= head_in;
         servo_ff     <= servo_in;
         slot_ff      <= slot_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
         goal_ff      <= goal_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.tx_byte   = tx_ff;
   assign rsp_ch.last_byte = last_ff;

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !load_out)
      else $error("byte loaded while no frame is in progress");
   a_crc_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && q_valid && q_cmd.kind != CMD_SET) |=> crc_ff == 16'h0000)
      else $error("checksum not cleared at frame start");
   a_servo_bound: assert property (@(posedge clock) disable iff (reset)
      servo_ff <= SERVO_LAST)
      else $error("servo counter beyond table");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_in) |=> state_ff == ST_IDLE)
      else $error("frame end marker outside the final checksum byte");

endmodule

/* hdl/servo_bus_frame_generator_top.sv */
// ----------------------------------------------------------------------------
// Servo bus frame generator
// Keeps servo goal positions and emits sync-write and read-request frames.
//
// The req_ch channel takes one command per transfer. Set commands update
// the goal table and give no output. A sync-write command gives a frame of
// 14 + 5 * SERVO_COUNT bytes and a read request gives 14 bytes on rsp_ch,
// one byte per transfer, with last_byte high on the final checksum byte.
// Commands pass through a two-entry queue to the frame sequencer. A command
// is stored in the queue, taken from it by the sequencer while idle, and its
// frame bytes are then loaded one at a time into the output register. A set
// command ends once taken, and no command is taken until a frame ends. The
// output register is reloaded in the cycle its byte is taken, so bytes
// follow back to back while rsp_ch stays ready; when the receiver stalls,
// the sequencer holds and the queue fills, after which req_ch.ready drops.
// Reset clears the goal table to zero, empties the queue and restores the
// configuration registers to their defaults. The user writes configuration
// through csr_* only while no frame is in progress; the block has no check.
// ----------------------------------------------------------------------------
module servo_bus_frame_generator_top #(
   parameter int SERVO_COUNT   = 5,
   parameter int POSITION_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   sbfg_req_if.sink    req_ch,
   sbfg_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import sbfg_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, pop_cmd;
   logic    push, pop, full, pop_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ID_OFFSET:       cfg_in.id_offset       = csr_write_data[7:0];
            CSR_GOAL_ADDRESS:    cfg_in.goal_address    = csr_write_data;
            CSR_PRESENT_ADDRESS: cfg_in.present_address = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.id_offset       <= ID_OFFSET_RESET;
         cfg_ff.goal_address    <= GOAL_ADDRESS_RESET;
         cfg_ff.present_address <= PRESENT_ADDRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbfg_front #(
      .SERVO_COUNT  (SERVO_COUNT),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .req_ch(req_ch),
      .q_full(full),
      .q_push(push),
      .q_cmd (push_cmd)
   );

   sbfg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .pop_valid(pop_valid),
      .pop_cmd  (pop_cmd)
   );

   sbfg_back #(
      .SERVO_COUNT  (SERVO_COUNT),
      .POSITION_BITS(POSITION_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_valid(pop_valid),
      .q_cmd  (pop_cmd),
      .q_pop  (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
